// ===== src/ccfr_pkg.sv =====
// Shared types, constants and the CRC-32 byte function for the COBS frame receiver.
`default_nettype none

package ccfr_pkg;

    localparam logic [7:0]  DELIM_BYTE      = 8'h00;
    localparam logic [7:0]  FULL_GROUP_CODE = 8'hFF;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
    localparam int          MIN_FRAME_BYTES = 5;
    localparam int          TAIL_BYTES      = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_CRC_BAD  = 2'd3
    } ccfr_status_t;

    typedef struct packed {
        logic         valid;
        logic         is_status;
        logic [7:0]   payload_byte;
        ccfr_status_t frame_status;
        logic [7:0]   payload_length;
    } ccfr_result_t;

    // One byte of a reflected CRC-32, eight bit steps unrolled.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/ccfr_core.sv =====
// Frame state, COBS decode, CRC tail delay line and end-of-frame judgment.
`default_nettype none

module ccfr_core #(
    parameter int RX_BUFFER_BYTES = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            rx_byte,
    output ccfr_pkg::ccfr_result_t     result
);
    import ccfr_pkg::*;

    localparam int CNT_W = $clog2(RX_BUFFER_BYTES);
    localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(RX_BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] MIN_LEN   = CNT_W'(MIN_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [2:0]       TAIL_FULL = 3'(TAIL_BYTES);

    logic [CNT_W-1:0] encoded_reg, encoded_next;
    logic [CNT_W-1:0] decoded_reg, decoded_next;
    logic [7:0]       group_reg, group_next;
    logic             zpend_reg, zpend_next;
    logic [2:0]       fill_reg, fill_next;
    logic [31:0]      crc_reg, crc_next;
    logic [7:0]       tail_reg [TAIL_BYTES];
    logic [7:0]       tail_next [TAIL_BYTES];

    logic             push_en;
    logic [7:0]       push_byte;
    logic [CNT_W-1:0] plen_raw;
    logic [LEN_W-1:0] plen_wide;
    logic [31:0]      recv_crc;

    always_comb
    begin
        encoded_next = encoded_reg;
        decoded_next = decoded_reg;
        group_next   = group_reg;
        zpend_next   = zpend_reg;
        fill_next    = fill_reg;
        crc_next     = crc_reg;
        tail_next    = tail_reg;
        push_en      = 1'b0;
        push_byte    = rx_byte;
        result       = '0;
        plen_raw     = decoded_reg - CNT_W'(fill_reg);
        plen_wide    = LEN_W'(plen_raw);
        recv_crc     = {tail_reg[3], tail_reg[2], tail_reg[1], tail_reg[0]};

        if (step)
        begin
            if (rx_byte == DELIM_BYTE)
            begin
                if (encoded_reg != '0)
                begin
                    result.valid     = 1'b1;
                    result.is_status = 1'b1;
                    if (encoded_reg < MIN_LEN)
                    begin
                        result.frame_status = ST_SHORT;
                    end
                    else if (group_reg != 8'd0)
                    begin
                        result.frame_status = ST_OVERRUN;
                    end
                    else if (decoded_reg < MIN_LEN)
                    begin
                        result.frame_status = ST_SHORT;
                    end
                    else if (recv_crc == ~crc_reg)
                    begin
                        result.frame_status = ST_OK;
                    end
                    else
                    begin
                        result.frame_status = ST_CRC_BAD;
                    end
                    result.payload_length = (plen_wide > LEN_W'(255)) ? 8'hFF
                                                                      : plen_wide[7:0];
                end
                encoded_next = '0;
                decoded_next = '0;
                group_next   = 8'd0;
                zpend_next   = 1'b0;
                fill_next    = 3'd0;
                crc_next     = CRC_INIT;
                for (int i = 0; i < TAIL_BYTES; i++) begin
                    tail_next[i] = 8'd0;
                end
            end
            else if (encoded_reg < BUF_LIMIT)
            begin
                encoded_next = encoded_reg + CNT_ONE;
                if (group_reg == 8'd0)
                begin
                    // Code byte: the previous group's implied zero is now known to be real.
                    push_en    = zpend_reg;
                    push_byte  = DELIM_BYTE;
                    group_next = rx_byte - 8'd1;
                    zpend_next = (rx_byte != FULL_GROUP_CODE);
                end
                else
                begin
                    push_en    = 1'b1;
                    group_next = group_reg - 8'd1;
                end

                if (push_en)
                begin
                    decoded_next = decoded_reg + CNT_ONE;
                    if (fill_reg == TAIL_FULL)
                    begin
                        result.valid        = 1'b1;
                        result.payload_byte = tail_reg[0];
                        crc_next            = crc_byte(crc_reg, tail_reg[0]);
                        for (int i = 0; i < TAIL_BYTES - 1; i++) begin
                            tail_next[i] = tail_reg[i+1];
                        end
                        tail_next[TAIL_BYTES-1] = push_byte;
                    end
                    else
                    begin
                        tail_next[fill_reg[1:0]] = push_byte;
                        fill_next                = fill_reg + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoded_reg <= '0;
            decoded_reg <= '0;
            group_reg   <= 8'd0;
            zpend_reg   <= 1'b0;
            fill_reg    <= 3'd0;
            crc_reg     <= CRC_INIT;
            for (int i = 0; i < TAIL_BYTES; i++) begin
                tail_reg[i] <= 8'd0;
            end
        end
        else
        begin
            encoded_reg <= encoded_next;
            decoded_reg <= decoded_next;
            group_reg   <= group_next;
            zpend_reg   <= zpend_next;
            fill_reg    <= fill_next;
            crc_reg     <= crc_next;
            tail_reg    <= tail_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cobs_crc32_frame_receiver.sv =====
// Top level of the COBS frame receiver with CRC-32 check: input and result registers.
//
//  channel  | valid      | ready      | beat fields
//  ---------+------------+------------+-------------------------------------------------
//  receive  | rx_valid   | rx_ready   | rx_byte
//  result   | out_valid  | out_ready  | is_status, payload_byte, frame_status,
//           |            |            | payload_length
//
// Each received byte is taken into an input register, then decoded combinationally by the
// core (COBS group tracking, four-byte CRC tail delay, one unrolled CRC-32 byte step)
// and its result, if any, lands in the result register. With out_ready held high the
// block takes one beat per cycle. A stalled result register holds the pipeline, and
// rx_ready then falls once the input register is also full. Reset is asynchronous and
// active low and returns the frame state to empty with the CRC preset to all ones; no
// clearing pass is needed.
`default_nettype none

module cobs_crc32_frame_receiver #(
    parameter int RX_BUFFER_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            is_status,
    output logic [7:0]      payload_byte,
    output logic [1:0]      frame_status,
    output logic [7:0]      payload_length
);
    import ccfr_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         advance;
    logic         step;
    ccfr_result_t core_result;

    logic         out_valid_reg;
    logic         is_status_reg;
    logic [7:0]   payload_byte_reg;
    logic [1:0]   frame_status_reg;
    logic [7:0]   payload_length_reg;

    // The held byte moves on whenever the result register is free or being emptied.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign rx_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_valid && rx_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    ccfr_core #(
        .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .rx_byte(in_byte_reg),
        .result (core_result)
    );

    // Result register: loads when the core produces a beat, empties on acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && core_result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && core_result.valid)
        begin
            is_status_reg      <= core_result.is_status;
            payload_byte_reg   <= core_result.payload_byte;
            frame_status_reg   <= core_result.frame_status;
            payload_length_reg <= core_result.payload_length;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_status      = is_status_reg;
    assign payload_byte   = payload_byte_reg;
    assign frame_status   = frame_status_reg;
    assign payload_length = payload_length_reg;

endmodule

`default_nettype wire
